>>> hdl/wu_subpixel_plot_framebuffer_unit_defines.svh
// Assertion macros for the subpixel plot frame buffer.
// Included by the checker; no other dependencies.
`ifndef WU_SUBPIXEL_PLOT_FRAMEBUFFER_UNIT_DEFINES_SVH
`define WU_SUBPIXEL_PLOT_FRAMEBUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define WUSPF_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("wuspf check failed");

// next-cycle implication
`define WUSPF_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("wuspf check failed");

`endif

>>> hdl/wuspf_pkg.sv
// Shared types for the subpixel plot frame buffer: commands, controller
// states and the control/status bundles between controller and datapath.
package wuspf_pkg;

  typedef enum logic [1:0] {
    CMD_FILL  = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_SPLAT = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_PLOT,
    ST_WEIGHT,
    ST_NB_ISSUE,
    ST_NB_SUM,
    ST_PIX_WRITE,
    ST_READ,
    ST_READ_DONE
  } state_t;

  typedef struct packed {
    logic load_item;   // latch input item, clear counters
    logic cfg_we;      // write row order register
    logic sweep_we;    // write store at sweep counter
    logic sweep_zero;  // sweep writes black
    logic base_load;   // latch pixel address, issue read, latch products
    logic wt_load;     // compute Wu weights
    logic nb_next;     // advance to next neighbor
    logic sum_load;    // saturating add into write color
    logic pix_we;      // write one LED of current pixel
    logic out_load;    // load read result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic led_last;
    logic pix_in_rng;
    logic nb_last;
    logic is_splat;
  } ctrl_stat_t;

endpackage

>>> hdl/wu_subpixel_plot_framebuffer_unit.sv
// Frame buffer for an RGB LED matrix with plot, fill, read and Wu subpixel
// splat. Top level; uses wuspf_pkg, wuspf_ctrl, wuspf_dp.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one command item: cmd, x_pos,
//    y_pos (7.8 fixed point) and a color. One item is worked at a time;
//    in_ready is high only while the controller is idle.
//  - Output channel (out_valid/out_ready) returns pixel_color for reads only.
//    The result sits in an output register, so new items are taken while a
//    read result waits; a second read stalls in its last step until taken.
//  - Config channel (cfg_valid/cfg_ready) writes row_order_parallel; always
//    ready, meant to be written while idle.
// Steps per item (L = LEDS_PER_PIXEL, N = W*H*L LEDs), one LED write at a
// time through the single write port of the frame store:
//  - fill: write N LEDs; plot: address, L writes (none if off-matrix);
//  - read: address, result; splat: weights, per neighbor read, sum, L writes.
// Reset: the controller sweeps the store to black, one LED per cycle, with
// in_ready low; config writes are still taken.
module wu_subpixel_plot_framebuffer_unit import wuspf_pkg::*; #(
  parameter int MATRIX_WIDTH   = 16,
  parameter int MATRIX_HEIGHT  = 16,
  parameter int LEDS_PER_PIXEL = 1
) (
  input  logic        clk,
  input  logic        rst,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        row_order_parallel,
  // command items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [14:0] x_pos,
  input  logic [14:0] y_pos,
  input  logic [7:0]  color_red,
  input  logic [7:0]  color_green,
  input  logic [7:0]  color_blue,
  // read results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_color
);

  ctrl_cmd_t  ctl;
  ctrl_stat_t stat;
  cmd_t       cmd_in;

  assign cmd_in = cmd_t'(cmd);

  // sequencing: clear sweep, command dispatch, neighbor walk, result hold
  wuspf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  // addressing, weights, blend and the frame store itself
  wuspf_dp #(
    .MATRIX_WIDTH   (MATRIX_WIDTH),
    .MATRIX_HEIGHT  (MATRIX_HEIGHT),
    .LEDS_PER_PIXEL (LEDS_PER_PIXEL)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .stat               (stat),
    .row_order_parallel (row_order_parallel),
    .cmd                (cmd_in),
    .x_pos              (x_pos),
    .y_pos              (y_pos),
    .color_red          (color_red),
    .color_green        (color_green),
    .color_blue         (color_blue),
    .pixel_color        (pixel_color)
  );

endmodule

>>> hdl/wuspf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wuspf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/wuspf_dp.sv
// Datapath: item registers, pixel address, Wu weights, saturating blend,
// frame store RAM and read result register. Uses wuspf_pkg and wuspf_ram.
module wuspf_dp import wuspf_pkg::*; #(
  parameter int MATRIX_WIDTH   = 16,
  parameter int MATRIX_HEIGHT  = 16,
  parameter int LEDS_PER_PIXEL = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   ctl,
  output ctrl_stat_t  stat,
  input  logic        row_order_parallel,
  input  cmd_t        cmd,
  input  logic [14:0] x_pos,
  input  logic [14:0] y_pos,
  input  logic [7:0]  color_red,
  input  logic [7:0]  color_green,
  input  logic [7:0]  color_blue,
  output logic [23:0] pixel_color
);

  localparam int LED_COUNT = MATRIX_WIDTH * MATRIX_HEIGHT * LEDS_PER_PIXEL;
  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [AW-1:0] LAST_LED = AW'(LED_COUNT - 1);
  localparam logic [AW-1:0] LAST_OFS = AW'(LEDS_PER_PIXEL - 1);

  function automatic logic [7:0] corner_weight(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] p;
    p = 16'(a) * 16'(b) + 16'(a) + 16'(b);
    return p[15:8];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] o, input logic [7:0] p);
    logic [8:0] s;
    s = {1'b0, o} + {1'b0, p};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  logic          order_par;
  cmd_t          cmd_q;
  logic [6:0]    col_q, row_q;
  logic [7:0]    fx_q, fy_q;
  logic [7:0]    red_q, green_q, blue_q;
  logic [23:0]   wr_color;
  logic [1:0]    nb;
  logic [AW-1:0] cnt;
  logic [AW-1:0] base_addr;
  logic          in_rng_q;
  logic [7:0]    wt [4];
  logic [7:0]    prod_r, prod_g, prod_b;

  // neighbor coordinates (nb is zero for plot and read)
  logic [7:0]    cx, cy, colm;
  logic          in_rng;
  logic [15:0]   pix;
  logic [17:0]   led_full;
  logic [AW-1:0] addr;
  logic [7:0]    w_sel, xx, yy;
  logic [15:0]   mr, mg, mb;

  logic          ram_we;
  logic [AW-1:0] ram_wr_addr;
  logic [23:0]   ram_wr_data;
  logic [23:0]   rd_data;

  assign cx     = {1'b0, col_q} + 8'(nb[0]);
  assign cy     = {1'b0, row_q} + 8'(nb[1]);
  assign in_rng = (cx < 8'(MATRIX_WIDTH)) && (cy < 8'(MATRIX_HEIGHT));
  assign colm   = (order_par || !cy[0]) ? cx : 8'(MATRIX_WIDTH - 1) - cx;
  assign pix    = 16'(cy) * 16'(MATRIX_WIDTH) + 16'(colm);
  assign led_full = 18'(pix) * 18'(LEDS_PER_PIXEL);
  assign addr   = led_full[AW-1:0];

  assign w_sel = wt[nb];
  assign mr    = 16'(red_q) * 16'(w_sel);
  assign mg    = 16'(green_q) * 16'(w_sel);
  assign mb    = 16'(blue_q) * 16'(w_sel);

  // fx*255>>8 equals fx-1 for nonzero fx
  assign xx = fx_q - 8'(fx_q != 8'd0);
  assign yy = fy_q - 8'(fy_q != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      order_par <= 1'b0;
      nb        <= 2'd0;
      cnt       <= '0;
    end else begin
      if (ctl.cfg_we) begin
        order_par <= row_order_parallel;
      end
      if (ctl.load_item) begin
        nb <= 2'd0;
      end else if (ctl.nb_next) begin
        nb <= nb + 2'd1;
      end
      if (ctl.load_item || ctl.base_load || ctl.sum_load) begin
        cnt <= '0;
      end else if (ctl.sweep_we || ctl.pix_we) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_q    <= cmd;
      col_q    <= x_pos[14:8];
      row_q    <= y_pos[14:8];
      fx_q     <= x_pos[7:0];
      fy_q     <= y_pos[7:0];
      red_q    <= color_red;
      green_q  <= color_green;
      blue_q   <= color_blue;
      wr_color <= {color_red, color_green, color_blue};
    end else if (ctl.sum_load) begin
      wr_color <= {sat_add(rd_data[23:16], prod_r),
                   sat_add(rd_data[15:8], prod_g),
                   sat_add(rd_data[7:0], prod_b)};
    end
    if (ctl.wt_load) begin
      wt[0] <= corner_weight(~xx, ~yy);
      wt[1] <= corner_weight(xx, ~yy);
      wt[2] <= corner_weight(~xx, yy);
      wt[3] <= corner_weight(xx, yy);
    end
    if (ctl.base_load) begin
      base_addr <= addr;
      in_rng_q  <= in_rng;
      prod_r    <= mr[15:8];
      prod_g    <= mg[15:8];
      prod_b    <= mb[15:8];
    end
    if (ctl.out_load) begin
      pixel_color <= in_rng_q ? rd_data : 24'd0;
    end
  end

  assign ram_we      = ctl.sweep_we || ctl.pix_we;
  assign ram_wr_addr = ctl.sweep_we ? cnt : base_addr + cnt;
  assign ram_wr_data = ctl.sweep_zero ? 24'd0 : wr_color;

  wuspf_ram #(
    .WIDTH (24),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ctl.base_load),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign stat.sweep_last = (cnt == LAST_LED);
  assign stat.led_last   = (cnt == LAST_OFS);
  assign stat.pix_in_rng = in_rng;
  assign stat.nb_last    = (nb == 2'd3);
  assign stat.is_splat   = (cmd_q == CMD_SPLAT);

endmodule

>>> hdl/wuspf_ctrl.sv
// Controller state machine: sequences clear, fill, plot, splat and read
// over the datapath. Uses wuspf_pkg.
module wuspf_ctrl import wuspf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       cmd,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ctrl_cmd_t  ctl,
  input  ctrl_stat_t stat
);

  state_t state, state_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.cfg_we = cfg_valid;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ctl.sweep_we   = 1'b1;
        ctl.sweep_zero = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          unique case (cmd)
            CMD_FILL:  state_next = ST_FILL;
            CMD_PLOT:  state_next = ST_PLOT;
            CMD_SPLAT: state_next = ST_WEIGHT;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        ctl.sweep_we = 1'b1;
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_PLOT: begin
        ctl.base_load = 1'b1;
        state_next = stat.pix_in_rng ? ST_PIX_WRITE : ST_IDLE;
      end
      ST_WEIGHT: begin
        ctl.wt_load = 1'b1;
        state_next  = ST_NB_ISSUE;
      end
      ST_NB_ISSUE: begin
        priority if (stat.pix_in_rng) begin
          ctl.base_load = 1'b1;
          state_next    = ST_NB_SUM;
        end else if (stat.nb_last) begin
          state_next = ST_IDLE;
        end else begin
          ctl.nb_next = 1'b1;
        end
      end
      ST_NB_SUM: begin
        ctl.sum_load = 1'b1;
        state_next   = ST_PIX_WRITE;
      end
      ST_PIX_WRITE: begin
        ctl.pix_we = 1'b1;
        if (stat.led_last) begin
          if (stat.is_splat && !stat.nb_last) begin
            ctl.nb_next = 1'b1;
            state_next  = ST_NB_ISSUE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        ctl.base_load = 1'b1;
        state_next    = ST_READ_DONE;
      end
      ST_READ_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/wuspf_chk.sv
// Port-level checker for the frame buffer top level, bound below.
// Depends on the assertion macro header.
`include "wu_subpixel_plot_framebuffer_unit_defines.svh"

module wuspf_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a stalled result stays offered
  `WUSPF_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // reset starts the clearing sweep, so no item is taken right after
  `WUSPF_ASSERT_NXT(a_rst_clear, clk, 1'b0, rst, !in_ready)

  // one item at a time: every accepted command takes the block out of idle
  `WUSPF_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)

  // a read result never appears the cycle after an accept
  `WUSPF_ASSERT_NXT(a_no_early_out, clk, rst, in_valid && in_ready, !$rose(out_valid))

endmodule

bind wu_subpixel_plot_framebuffer_unit wuspf_chk u_chk (.*);
